@@ rtl/core/rhib_pkg.sv @@
`timescale 1ns / 1ps
package rhib_pkg;
  localparam int SidePixels = 256;
  localparam int AddrW = 16;
  localparam int AccW = 40;
  localparam logic signed [AccW-1:0] AccMax = {1'b0, {(AccW-1){1'b1}}};
  localparam logic signed [AccW-1:0] AccMin = {1'b1, {(AccW-1){1'b0}}};

  typedef enum logic [2:0] {
    CFG_HALF_SIDE = 3'd0,
    CFG_PPL       = 3'd1,
    CFG_SIDE      = 3'd2,
    CFG_INVERT    = 3'd3,
    CFG_KSCALE    = 3'd4,
    CFG_ROOT      = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    OP_BIN  = 1'b0,
    OP_READ = 1'b1
  } op_t;

  // One classified item as it passes from the front end to the back end.
  typedef struct packed {
    logic             is_read;
    logic             active;
    logic [7:0]       col;
    logic [7:0]       row;
    logic [17:0]      weight;
    logic             clear;
  } cmd_t;

  typedef struct packed {
    logic             landed;
    logic [7:0]       hit_col;
    logic [7:0]       hit_row;
    logic [AccW-1:0]  pixel_value;
    logic             saturated;
    logic             root_of_negative;
  } res_t;
endpackage

@@ rtl/core/ray_hit_image_binner_unit.sv @@
`timescale 1ns / 1ps
// Each half has its own bit-serial root unit, one result bit per cycle. The front
// takes a new item only when idle, once it has handed the last one on; the back
// likewise takes the next item only once its result has been taken; a two-entry
// queue sits between them. Reset: synchronous, active low; then a clearing pass
// writes zero to all 65536 pixels while input is held off.
module ray_hit_image_binner_unit (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data,
  input  logic         in_tvalid,
  output logic         in_tready,
  // operation[0]
  input  logic         in_tuser,
  // ray_x[31:0], ray_y[63:32], kx[79:64], ky[95:80], kz[111:96],
  // read_col[119:112], read_row[127:120], clear_on_read[128], zeros to 135
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // landed[0], hit_col[8:1], hit_row[16:9], pixel_value[56:17],
  // saturated[57], root_of_negative[58], zeros to 63
  output logic [63:0]  out_tdata
);
  import rhib_pkg::*;

  logic [30:0] half_r;
  logic [31:0] ppl_r;
  logic [8:0]  side_r;
  logic        inv_r, ks_r, root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= '0; ppl_r <= 32'd65536; side_r <= 9'd256;
      inv_r <= 1'b0; ks_r <= 1'b0; root_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_HALF_SIDE: half_r <= cfg_data[30:0];
        CFG_PPL:       ppl_r  <= cfg_data;
        CFG_SIDE:      side_r <= cfg_data[8:0];
        CFG_INVERT:    inv_r  <= cfg_data[0];
        CFG_KSCALE:    ks_r   <= cfg_data[0];
        CFG_ROOT:      root_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  logic fr_ready, clearing;
  logic c_valid, c_ready, q_valid, q_ready;
  cmd_t c_data, q_data;
  res_t res;

  assign in_tready = fr_ready && !clearing;

  rhib_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_tvalid && !clearing), .in_ready(fr_ready),
    .op(in_tuser), .ray_x(in_tdata[31:0]), .ray_y(in_tdata[63:32]),
    .kx(in_tdata[79:64]), .ky(in_tdata[95:80]), .kz(in_tdata[111:96]),
    .rcol(in_tdata[119:112]), .rrow(in_tdata[127:120]), .rclear(in_tdata[128]),
    .half_side(half_r), .ppl(ppl_r), .side(side_r), .invert(inv_r), .kscale(ks_r),
    .cmd_valid(c_valid), .cmd_ready(c_ready), .cmd(c_data)
  );

  rhib_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .wr_valid(c_valid), .wr_ready(c_ready), .wr_data(c_data),
    .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_data)
  );

  rhib_back u_back (
    .clk(clk), .rst_n(rst_n), .cmd_valid(q_valid), .cmd_ready(q_ready), .cmd(q_data),
    .invert(inv_r), .root_on(root_r), .clearing(clearing),
    .res_valid(out_tvalid), .res_ready(out_tready), .res(res)
  );

  assign out_tdata = {5'b0, res.root_of_negative, res.saturated, res.pixel_value,
                      res.hit_row, res.hit_col, res.landed};

  a_no_accept_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_tready) else $error("input taken during clearing pass");
  a_no_output_clearing: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !out_tvalid) else $error("result shown during clearing pass");
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !res.landed) |-> (res.hit_col == 8'd0 && res.hit_row == 8'd0))
    else $error("dropped hit reports a pixel");
endmodule

@@ rtl/core/rhib_isqrt.sv @@
`timescale 1ns / 1ps
module rhib_isqrt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        done,
  output logic [31:0] root
);
  import rhib_pkg::*;

  // Restoring bit-by-bit root, one result bit per cycle.
  logic [33:0] prem_r, prem_nxt;
  logic [63:0] src_r, src_nxt;
  logic [31:0] root_r, root_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [35:0] shifted;
  logic [35:0] sub;
  logic [35:0] diff;

  always_comb begin
    shifted  = {prem_r, src_r[63:62]};
    sub      = {2'b00, root_r, 2'b01};
    diff     = shifted - sub;
    prem_nxt = prem_r;
    src_nxt  = src_r;
    root_nxt = root_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      prem_nxt = '0;
      src_nxt  = radicand;
      root_nxt = '0;
      cnt_nxt  = 6'd32;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      src_nxt = {src_r[61:0], 2'b00};
      cnt_nxt = cnt_r - 6'd1;
      if (shifted >= sub) begin
        prem_nxt = diff[33:0];
        root_nxt = {root_r[30:0], 1'b1};
      end else begin
        prem_nxt = shifted[33:0];
        root_nxt = {root_r[30:0], 1'b0};
      end
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    root_r <= root_nxt;
    prem_r <= prem_nxt;
    src_r  <= src_nxt;
  end

  assign done = done_r;
  assign root = root_r;
endmodule

@@ rtl/core/rhib_front.sv @@
`timescale 1ns / 1ps
module rhib_front (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  op,
  input  logic [31:0]           ray_x,
  input  logic [31:0]           ray_y,
  input  logic [15:0]           kx,
  input  logic [15:0]           ky,
  input  logic [15:0]           kz,
  input  logic [7:0]            rcol,
  input  logic [7:0]            rrow,
  input  logic                  rclear,
  input  logic [30:0]           half_side,
  input  logic [31:0]           ppl,
  input  logic [8:0]            side,
  input  logic                  invert,
  input  logic                  kscale,
  output logic                  cmd_valid,
  input  logic                  cmd_ready,
  output rhib_pkg::cmd_t        cmd
);
  import rhib_pkg::*;

  typedef enum logic [2:0] {F_IDLE, F_MULX, F_MULY, F_KSQ, F_ROOT, F_OUT} fstate_t;
  fstate_t     st_r;
  logic        op_r;
  logic [31:0] px_r, py_r;
  logic [15:0] kx_r, ky_r, kz_r;
  logic [7:0]  rc_r, rr_r;
  logic        rcl_r;
  logic [32:0] mag_r;
  logic        neg_r;
  logic        ok_r;
  logic [7:0]  cx_r, cy_r;
  logic [1:0]  ki_r;
  logic [33:0] ksum_r;
  logic        sq_start_r;
  logic        sq_done;
  logic [31:0] sq_root;

  logic [8:0]  dim;
  always_comb begin
    dim = side;
    if (dim == 9'd0) dim = 9'd1;
    if (dim > 9'd256) dim = 9'd256;
  end

  // Shifted position for the axis selected by the state.
  logic signed [33:0] shifted;
  logic [31:0]        pos;
  assign pos = (st_r == F_MULX) ? px_r : py_r;
  always_comb begin
    shifted = invert ? -34'(signed'(pos)) : 34'(signed'(pos));
    shifted = shifted + 34'({3'b0, half_side});
  end

  logic [64:0] prod;
  logic [32:0] ip;
  logic        axis_ok;
  assign prod = mag_r * ppl;
  assign ip   = prod[64:32];
  assign axis_ok = (neg_r ? (ip == '0) : 1'b1) && (ip < 33'(dim));

  logic signed [15:0] ksel;
  logic [31:0]        ksq;
  assign ksel = (ki_r == 2'd0) ? kx_r : ((ki_r == 2'd1) ? ky_r : kz_r);
  assign ksq  = 32'($signed(ksel) * $signed(ksel));

  rhib_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start_r),
    .radicand({30'b0, ksum_r}), .done(sq_done), .root(sq_root)
  );

  // The axis product is taken in the cycle after the magnitude is registered.
  logic phase_r;
  always_ff @(posedge clk) begin
    sq_start_r <= rst_n && (st_r == F_KSQ) && (ki_r == 2'd2);
    if (!rst_n) begin
      st_r    <= F_IDLE;
      phase_r <= 1'b0;
    end else begin
      unique case (st_r)
        F_IDLE: if (in_valid) begin
          op_r <= op; px_r <= ray_x; py_r <= ray_y;
          kx_r <= kx; ky_r <= ky; kz_r <= kz;
          rc_r <= rcol; rr_r <= rrow; rcl_r <= rclear;
          phase_r <= 1'b0;
          ok_r <= 1'b1;
          st_r <= (op == OP_READ) ? F_OUT : F_MULX;
        end
        F_MULX, F_MULY: begin
          if (!phase_r) begin
            neg_r   <= shifted[33];
            mag_r   <= shifted[33] ? 33'(-shifted) : 33'(shifted);
            phase_r <= 1'b1;
          end else begin
            phase_r <= 1'b0;
            ok_r <= ok_r & axis_ok;
            if (st_r == F_MULX) begin
              cx_r <= ip[7:0];
              st_r <= F_MULY;
            end else begin
              cy_r <= ip[7:0];
              ki_r <= 2'd0;
              ksum_r <= '0;
              st_r <= (kscale && ok_r && axis_ok) ? F_KSQ : F_OUT;
            end
          end
        end
        F_KSQ: begin
          ksum_r <= ksum_r + 34'(ksq);
          ki_r   <= ki_r + 2'd1;
          if (ki_r == 2'd2) st_r <= F_ROOT;
        end
        F_ROOT: if (sq_done) st_r <= F_OUT;
        F_OUT: if (cmd_ready) st_r <= F_IDLE;
        default: st_r <= F_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    cmd.is_read = op_r;
    cmd.clear   = rcl_r;
    if (op_r == OP_READ) begin
      cmd.active = (9'(rc_r) < dim) && (9'(rr_r) < dim);
      cmd.col = rc_r;
      cmd.row = rr_r;
    end else begin
      cmd.active = ok_r;
      cmd.col = ok_r ? cx_r : 8'd0;
      cmd.row = ok_r ? cy_r : 8'd0;
      cmd.weight = kscale ? sq_root[17:0] : 18'd256;
    end
  end

  assign in_ready  = (st_r == F_IDLE);
  assign cmd_valid = (st_r == F_OUT);
endmodule

@@ rtl/core/rhib_fifo.sv @@
`timescale 1ns / 1ps
module rhib_fifo (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_valid,
  output logic            wr_ready,
  input  rhib_pkg::cmd_t  wr_data,
  output logic            rd_valid,
  input  logic            rd_ready,
  output rhib_pkg::cmd_t  rd_data
);
  import rhib_pkg::*;

  cmd_t       mem_r [2];
  logic [1:0] cnt_r;
  logic       wp_r, rp_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0; wp_r <= 1'b0; rp_r <= 1'b0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr) - 2'(rd);
    end
    if (wr) mem_r[wp_r] <= wr_data;
  end
endmodule

@@ rtl/core/rhib_back.sv @@
`timescale 1ns / 1ps
module rhib_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cmd_valid,
  output logic            cmd_ready,
  input  rhib_pkg::cmd_t  cmd,
  input  logic            invert,
  input  logic            root_on,
  output logic            clearing,
  output logic            res_valid,
  input  logic            res_ready,
  output rhib_pkg::res_t  res
);
  import rhib_pkg::*;

  typedef enum logic [2:0] {B_CLR, B_IDLE, B_READ, B_WRITE, B_ROOT, B_OUT} bstate_t;
  bstate_t         st_r;
  logic [AccW-1:0] mem [SidePixels*SidePixels];
  logic [AccW-1:0] rdata_r;
  logic [AddrW-1:0] addr_r;
  logic [AddrW-1:0] clr_r;
  cmd_t            c_r;
  res_t            res_r;
  logic            sq_start_r;
  logic            sq_done;
  logic [31:0]     sq_root;

  logic signed [AccW+1:0] sum;
  logic signed [AccW+1:0] w;
  assign w   = invert ? -(AccW+2)'(c_r.weight) : (AccW+2)'(c_r.weight);
  assign sum = (AccW+2)'(signed'(rdata_r)) + w;

  logic [AccW-1:0] acc;
  logic            sat;
  always_comb begin
    sat = 1'b0;
    acc = sum[AccW-1:0];
    if (sum > (AccW+2)'(AccMax)) begin acc = AccMax; sat = 1'b1; end
    if (sum < (AccW+2)'(signed'(AccMin))) begin acc = AccMin; sat = 1'b1; end
  end

  rhib_isqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start_r),
    .radicand({16'b0, rdata_r, 8'b0}), .done(sq_done), .root(sq_root)
  );

  logic            we;
  logic [AddrW-1:0] wa;
  logic [AccW-1:0] wd;
  always_comb begin
    we = 1'b0; wa = addr_r; wd = '0;
    if (st_r == B_CLR) begin
      we = 1'b1; wa = clr_r;
    end else if (st_r == B_WRITE && c_r.active) begin
      wd = c_r.is_read ? '0 : acc;
      we = c_r.is_read ? c_r.clear : 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rdata_r <= mem[addr_r];
  end

  // Result of the item once its pixel has been read; a rooted read of a non-negative pixel still needs its root.
  res_t wr_res;
  logic need_root;
  assign need_root = c_r.is_read && c_r.active && root_on && !rdata_r[AccW-1];
  always_comb begin
    wr_res = '0;
    if (!c_r.is_read) begin
      wr_res.landed    = c_r.active;
      wr_res.hit_col   = c_r.col;
      wr_res.hit_row   = c_r.row;
      wr_res.saturated = c_r.active & sat;
    end else if (c_r.active && root_on && rdata_r[AccW-1]) begin
      wr_res.root_of_negative = 1'b1;
    end else if (c_r.active && !root_on) begin
      wr_res.pixel_value = rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    sq_start_r <= rst_n && (st_r == B_WRITE) && need_root;
    if (!rst_n) begin
      st_r  <= B_CLR;
      clr_r <= '0;
    end else begin
      unique case (st_r)
        B_CLR: begin
          clr_r <= clr_r + 1'b1;
          if (clr_r == '1) st_r <= B_IDLE;
        end
        B_IDLE: if (cmd_valid) begin
          c_r    <= cmd;
          addr_r <= {cmd.row, cmd.col};
          st_r   <= B_READ;
        end
        B_READ: st_r <= B_WRITE;
        B_WRITE: begin
          res_r <= wr_res;
          st_r  <= need_root ? B_ROOT : B_OUT;
        end
        B_ROOT: if (sq_done) begin
          res_r.pixel_value <= AccW'(sq_root);
          st_r <= B_OUT;
        end
        B_OUT: if (res_ready) st_r <= B_IDLE;
        default: st_r <= B_IDLE;
      endcase
    end
  end

  assign cmd_ready = (st_r == B_IDLE);
  assign clearing  = (st_r == B_CLR);
  assign res_valid = (st_r == B_OUT);
  assign res       = res_r;
endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
module tb;
  import rhib_pkg::*;

  localparam int ClearCycles = 65536;
  localparam int DrainCycles = 200;
  localparam longint CycleLimit = 3000000;

  typedef struct packed {
    logic        op;
    logic [31:0] ray_x;
    logic [31:0] ray_y;
    logic [15:0] kx;
    logic [15:0] ky;
    logic [15:0] kz;
    logic [7:0]  rcol;
    logic [7:0]  rrow;
    logic        clr;
  } hit_item_t;

  typedef struct packed {
    logic        landed;
    logic [7:0]  col;
    logic [7:0]  row;
    logic [39:0] value;
    logic        sat;
    logic        rneg;
  } pixel_res_t;

  typedef struct {
    hit_item_t  item;
    logic       typed;
    pixel_res_t res;
  } stim_row_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [31:0]  cfg_data = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic         in_tuser = 1'b0;
  logic [135:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [63:0]  out_tdata;

  ray_hit_image_binner_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tuser(in_tuser), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow of the block's registers and image store.
  logic [30:0] half_side;
  logic [31:0] ppl;
  logic [8:0]  side_reg;
  logic        invert, kscale, root_rd;
  logic signed [39:0] image [SidePixels*SidePixels];

  pixel_res_t expected_pixels [$];
  int  errors = 0;
  int  in_idle_pct = 0;
  int  out_idle_pct = 0;
  longint cycles = 0;

  function automatic logic [63:0] int_root(logic [63:0] n);
    logic [63:0] r, t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic int unsigned side_used();
    int unsigned d;
    d = side_reg;
    if (d == 0) d = 1;
    if (d > 256) d = 256;
    if (d > SidePixels) d = SidePixels;
    return d;
  endfunction

  function automatic logic pixel_axis(logic [31:0] pos, int unsigned dim,
                                      output logic [7:0] idx);
    longint shifted, p;
    logic [63:0] mag, ip;
    p = longint'($signed(pos));
    shifted = (invert ? -p : p) + longint'(half_side);
    mag = shifted < 0 ? 64'(-shifted) : 64'(shifted);
    ip = (mag * 64'(ppl)) >> 32;
    idx = 0;
    if (shifted < 0 && ip != 0) return 1'b0;
    if (shifted < 0) ip = 0;
    if (ip >= dim) return 1'b0;
    idx = ip[7:0];
    return 1'b1;
  endfunction

  function automatic pixel_res_t bin_or_read(hit_item_t it);
    pixel_res_t r;
    int unsigned dim, a;
    logic [7:0] cx, cy;
    longint w, acc, kx, ky, kz, v;
    r = '{default: '0};
    dim = side_used();
    if (it.op == OP_BIN) begin
      if (pixel_axis(it.ray_x, dim, cx) && pixel_axis(it.ray_y, dim, cy)) begin
        a = cy * SidePixels + cx;
        w = 256;
        if (kscale) begin
          kx = $signed(it.kx);
          ky = $signed(it.ky);
          kz = $signed(it.kz);
          w = longint'(int_root(64'(kx * kx + ky * ky + kz * kz)));
        end
        acc = longint'(image[a]) + (invert ? -w : w);
        if (acc > longint'(AccMax)) begin acc = AccMax; r.sat = 1; end
        if (acc < longint'(AccMin)) begin acc = AccMin; r.sat = 1; end
        image[a] = acc[39:0];
        r.landed = 1;
        r.col = cx;
        r.row = cy;
      end
    end else if (it.rcol < dim && it.rrow < dim) begin
      a = it.rrow * SidePixels + it.rcol;
      v = image[a];
      if (!root_rd) r.value = v[39:0];
      else if (v < 0) r.rneg = 1;
      else r.value = 40'(int_root(64'(v) << 8));
      if (it.clr) image[a] = '0;
    end
    return r;
  endfunction

  function automatic logic [135:0] pack_item(hit_item_t it);
    return {7'd0, it.clr, it.rrow, it.rcol, it.kz, it.ky, it.kx, it.ray_y, it.ray_x};
  endfunction

  task automatic write_reg(cfg_idx_t idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_HALF_SIDE: half_side = val[30:0];
      CFG_PPL:       ppl = val;
      CFG_SIDE:      side_reg = val[8:0];
      CFG_INVERT:    invert = val[0];
      CFG_KSCALE:    kscale = val[0];
      default:       root_rd = val[0];
    endcase
  endtask

  // Waits for all outstanding results and then for the block to settle.
  task automatic drain();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic send(hit_item_t it, logic typed, pixel_res_t typed_res);
    pixel_res_t p;
    while ($urandom_range(99) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= it.op;
    in_tdata  <= pack_item(it);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    p = bin_or_read(it);
    if (typed && p != typed_res) begin
      $error("directed row disagrees with prediction");
      errors++;
    end
    expected_pixels.push_back(p);
  endtask

  task automatic send_gap();
    in_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic hit_item_t random_item();
    hit_item_t it;
    int unsigned dim;
    dim = side_used();
    it.op = ($urandom_range(99) < 30) ? OP_READ : OP_BIN;
    it.ray_x = $urandom;
    it.ray_y = $urandom;
    // Mostly positions that land, with the scale taken into account.
    if ($urandom_range(99) < 80 && ppl != 0) begin
      it.ray_x = 32'(($urandom_range(dim * 65536 - 1) * 64'h1_0000_0000 / 65536) / ppl) -
                 32'(half_side);
      it.ray_y = 32'(($urandom_range(dim * 65536 - 1) * 64'h1_0000_0000 / 65536) / ppl) -
                 32'(half_side);
      if (invert) begin
        it.ray_x = -it.ray_x;
        it.ray_y = -it.ray_y;
      end
    end
    it.kx = $urandom;
    it.ky = $urandom;
    it.kz = $urandom;
    it.rcol = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(dim - 1));
    it.rrow = ($urandom_range(3) == 0) ? 8'($urandom) : 8'($urandom_range(dim - 1));
    it.clr = $urandom_range(1);
    return it;
  endfunction

  // Receiver side and result check.
  always @(posedge clk) begin
    pixel_res_t got, want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.landed = out_tdata[0];
        got.col = out_tdata[8:1];
        got.row = out_tdata[16:9];
        got.value = out_tdata[56:17];
        got.sat = out_tdata[57];
        got.rneg = out_tdata[58];
        if (expected_pixels.size() == 0) begin
          $error("result transfer with nothing expected");
          errors++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.landed != want.landed) begin
            $error("landed exp %0d got %0d", want.landed, got.landed); errors++;
          end
          if (got.col != want.col) begin
            $error("hit_col exp %0d got %0d", want.col, got.col); errors++;
          end
          if (got.row != want.row) begin
            $error("hit_row exp %0d got %0d", want.row, got.row); errors++;
          end
          if (got.value != want.value) begin
            $error("pixel_value exp %h got %h", want.value, got.value); errors++;
          end
          if (got.sat != want.sat) begin
            $error("saturated exp %0d got %0d", want.sat, got.sat); errors++;
          end
          if (got.rneg != want.rneg) begin
            $error("root_of_negative exp %0d got %0d", want.rneg, got.rneg); errors++;
          end
        end
      end
      out_tready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic hit_item_t hit(logic op, logic [31:0] x, logic [31:0] y,
                                    logic [15:0] k, logic [7:0] c, logic [7:0] r,
                                    logic clr);
    hit_item_t it;
    it = '{op: op, ray_x: x, ray_y: y, kx: k, ky: ~k, kz: k, rcol: c, rrow: r, clr: clr};
    return it;
  endfunction

  function automatic pixel_res_t res(logic l, logic [7:0] c, logic [7:0] r,
                                     logic [39:0] v, logic s, logic n);
    pixel_res_t p;
    p = '{landed: l, col: c, row: r, value: v, sat: s, rneg: n};
    return p;
  endfunction

  stim_row_t directed [$];

  initial begin
    hit_item_t it;
    for (int i = 0; i < SidePixels * SidePixels; i++) image[i] = '0;
    half_side = 0; ppl = 65536; side_reg = 256; invert = 0; kscale = 0; root_rd = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    repeat (ClearCycles + 50) @(posedge clk);

    // Reset settings: one pixel per length unit, origin at pixel 0.
    directed = '{
      '{hit(OP_READ, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0)},
      '{hit(OP_BIN, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0), 1, res(1, 0, 0, 0, 0, 0)},
      '{hit(OP_BIN, 32'h0005_8000, 32'h00FF_FFFF, 0, 0, 0, 0), 1, res(1, 5, 255, 0, 0, 0)},
      '{hit(OP_BIN, 32'h0100_0000, 32'h0000_0000, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 0)},
      '{hit(OP_BIN, 32'hFFFF_FFFF, 32'h0000_0001, 0, 0, 0, 0), 1, res(1, 0, 0, 0, 0, 0)},
      '{hit(OP_BIN, 32'h8000_0000, 32'h7FFF_FFFF, 16'h7FFF, 0, 0, 0), 1,
        res(0, 0, 0, 0, 0, 0)},
      '{hit(OP_READ, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 40'd512, 0, 0)},
      '{hit(OP_READ, 0, 0, 0, 5, 255, 1), 1, res(0, 0, 0, 40'd256, 0, 0)},
      '{hit(OP_READ, 0, 0, 0, 5, 255, 0), 1, res(0, 0, 0, 40'd0, 0, 0)},
      '{hit(OP_READ, 0, 0, 16'hFFFF, 255, 255, 1), 0, res(0, 0, 0, 0, 0, 0)}
    };
    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].res);
    send_gap();
    drain();

    // Inverted, weighted, rooted reads on a smaller image.
    write_reg(CFG_HALF_SIDE, 32'h7FFF_FFFF);
    write_reg(CFG_PPL, 32'hFFFF_FFFF);
    write_reg(CFG_SIDE, 9'd0);
    write_reg(CFG_INVERT, 1);
    write_reg(CFG_KSCALE, 1);
    write_reg(CFG_ROOT, 1);
    send(hit(OP_BIN, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000, 0, 0, 0), 0, '{default: '0});
    send(hit(OP_BIN, 32'h7FFF_0000, 32'h7FFF_FFFF, 16'h0100, 0, 0, 0), 0, '{default: '0});
    send(hit(OP_READ, 0, 0, 0, 0, 0, 0), 1, res(0, 0, 0, 0, 0, 1));
    send(hit(OP_READ, 0, 0, 0, 1, 0, 0), 1, res(0, 0, 0, 0, 0, 0));
    send(hit(OP_READ, 0, 0, 0, 0, 0, 1), 0, '{default: '0});
    send_gap();
    drain();
    write_reg(CFG_PPL, 0);
    send(hit(OP_BIN, 32'h1234_5678, 32'h8765_4321, 16'h00FF, 0, 0, 0), 0, '{default: '0});
    send_gap();
    drain();

    // Random traffic in six phases, each with its own settings; idling is set anew in every other phase.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin in_idle_pct = 7;  out_idle_pct = 88; end
        2: begin in_idle_pct = 88; out_idle_pct = 7;  end
        4: begin in_idle_pct = 0;  out_idle_pct = 0;  end
        default: ;
      endcase
      write_reg(CFG_HALF_SIDE, (phase % 2) ? 32'h0008_0000 : $urandom_range(32'h0010_0000));
      write_reg(CFG_PPL, (phase == 5) ? 32'h0004_0000 : 32'h0001_0000 + $urandom_range(32'h8000));
      write_reg(CFG_SIDE, (phase == 1) ? 9'd511 : ((phase == 3) ? 9'd1 : 9'($urandom_range(2, 64))));
      write_reg(CFG_INVERT, $urandom_range(1));
      write_reg(CFG_KSCALE, $urandom_range(1));
      write_reg(CFG_ROOT, $urandom_range(1));
      for (int n = 0; n < 200; n++) begin
        it = random_item();
        send(it, 0, '{default: '0});
        if (n == 100) begin
          send_gap();
          while (expected_pixels.size() != 0) @(posedge clk);
        end
      end
      send_gap();
      drain();
    end

    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule

@@ filelist.f @@
rtl/core/rhib_pkg.sv
rtl/core/rhib_isqrt.sv
rtl/core/rhib_front.sv
rtl/core/rhib_fifo.sv
rtl/core/rhib_back.sv
rtl/core/ray_hit_image_binner_unit.sv
test/tb.sv
